### hw/rtl/rms_onset_detector_assert.svh
// ----------------------------------------------------------------------------
// RMS onset detector assertion macros
// Shared concurrent assertion forms for the onset detector modules.
// ----------------------------------------------------------------------------
`ifndef RMS_ONSET_DETECTOR_ASSERT_SVH
`define RMS_ONSET_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ROD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rod_pkg.sv
// ----------------------------------------------------------------------------
// RMS onset detector package
// Shared types, widths, reset values and helper functions.
// ----------------------------------------------------------------------------
package rod_pkg;

    localparam int MAX_WINDOW_DEF = 2048;
    localparam int INDEX_BITS_DEF = 24;

    localparam int SAMPLE_W = 16;
    localparam int WLEN_W   = 12;
    localparam int STEP_W   = 16;
    localparam int SEARCH_W = 24;
    localparam int ONSET_W  = 24;
    localparam int RISE_W   = 16;

    localparam int SQ_W      = 31;          // square of a 16-bit magnitude
    localparam int Q_W       = 31;          // mean square never exceeds 2^30
    localparam int RAD_W     = 32;
    localparam int ROOT_W    = RISE_W;
    localparam int ROOT_ITER = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;

    localparam int QUEUE_DEPTH = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] REG_STEP_LEN   = 2'd1;
    localparam logic [1:0] REG_SEARCH_END = 2'd2;

    localparam logic [WLEN_W-1:0]   WINDOW_LEN_RST = 12'd1200;
    localparam logic [STEP_W-1:0]   STEP_LEN_RST   = 16'd480;
    localparam logic [SEARCH_W-1:0] SEARCH_END_RST = 24'd0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } item_t;

    typedef struct packed {
        logic [ONSET_W-1:0] onset_index;
        logic [RISE_W-1:0]  rise;
        logic               found;
    } result_t;

    typedef struct packed {
        logic [WLEN_W-1:0]   window_len;
        logic [STEP_W-1:0]   step_len;
        logic [SEARCH_W-1:0] search_end;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CLASS,
        B_ADD,
        B_SUB,
        B_RC_READ,
        B_RC_SQ,
        B_RC_ACC,
        B_CHECK,
        B_ROOT,
        B_UPDATE,
        B_ADVANCE,
        B_FINISH
    } back_state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT,
        R_FIN
    } root_state_t;

    function automatic logic [SQ_W-1:0] square(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0]   mag;
        logic [2*SAMPLE_W-1:0] prod;
        mag = s;
        if (s[SAMPLE_W-1])
        begin
            mag = ~mag + 1'b1;
        end
        prod = {{SAMPLE_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, mag};
        return prod[SQ_W-1:0];
    endfunction

endpackage

### hw/rtl/rod_queue.sv
// ----------------------------------------------------------------------------
// rod_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module rod_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              full,
    output logic              empty
);
    import rod_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/rod_front.sv
// ----------------------------------------------------------------------------
// rod_front
// Accepts sample beats, numbers them and flags those past the index limit.
// ----------------------------------------------------------------------------
module rod_front #(
    parameter  int INDEX_BITS = rod_pkg::INDEX_BITS_DEF,
    localparam int QDATA_W    = INDEX_BITS + 1 + $bits(rod_pkg::item_t)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rod_pkg::item_t      item,
    output logic                full,
    input  logic                q_full,
    output logic                q_push,
    output logic [QDATA_W-1:0]  q_data
);
    import rod_pkg::*;

    logic [INDEX_BITS-1:0] count_reg, count_next;
    logic                  store;
    logic                  accept;

    // The all-ones index is the saturation point: such samples are not stored.
    assign store  = (count_reg != {INDEX_BITS{1'b1}});
    assign accept = push && !q_full;
    assign full   = q_full;
    assign q_push = accept;
    assign q_data = {count_reg, store, item};

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (item.last)
            begin
                count_next = '0;
            end
            else if (store)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/rod_root.sv
// ----------------------------------------------------------------------------
// rod_root
// Iterative mean and root: restoring divide of the window sum by the window
// length, one quotient bit a cycle, then a two-bits-a-cycle integer sqrt.
// ----------------------------------------------------------------------------
module rod_root #(
    parameter int SUM_W = 42
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SUM_W-1:0]           dividend,
    input  logic [rod_pkg::WLEN_W-1:0] divisor,
    output rod_pkg::root_stat_t        stat,
    output logic [rod_pkg::ROOT_W-1:0] root
);
    import rod_pkg::*;

    localparam int CNT_MAX = (SUM_W > ROOT_ITER) ? SUM_W : ROOT_ITER;
    localparam int CNT_W   = $clog2(CNT_MAX);

    root_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [WLEN_W-1:0]   drem_reg, drem_next;
    logic [WLEN_W-1:0]   dsr_reg, dsr_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    srem_reg, srem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [WLEN_W:0]     dtrial, ddiff;
    logic                dge;
    logic [REM_W+1:0]    ssh, strial, sdiff;
    logic                sge;

    assign dtrial = {drem_reg, dvd_reg[SUM_W-1]};
    assign ddiff  = dtrial - {1'b0, dsr_reg};
    assign dge    = (dtrial >= {1'b0, dsr_reg});

    assign ssh    = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign strial = (REM_W + 2)'({root_reg, 2'b01});
    assign sdiff  = ssh - strial;
    assign sge    = (ssh >= strial);

    assign stat.busy = (state_reg != R_IDLE);
    assign stat.done = (state_reg == R_FIN);
    assign root      = root_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        drem_next  = drem_reg;
        dsr_next   = dsr_reg;
        rad_next   = rad_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = dividend;
                    dsr_next   = divisor;
                    drem_next  = '0;
                    cnt_next   = CNT_W'(SUM_W - 1);
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                // Shift the quotient bit in behind the dividend.
                drem_next = dge ? ddiff[WLEN_W-1:0] : dtrial[WLEN_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], dge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rad_next   = RAD_W'(dvd_next[Q_W-1:0]);
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(ROOT_ITER - 1);
                    state_next = R_SQRT;
                end
            end
            R_SQRT:
            begin
                srem_next = sge ? sdiff[REM_W-1:0] : ssh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = R_FIN;
                end
            end
            R_FIN:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
        dsr_reg  <= dsr_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

endmodule

### hw/rtl/rod_back.sv
// ----------------------------------------------------------------------------
// rod_back
// Sample ring, sliding sum of squares, window close and onset tracking,
// and the result register.
// ----------------------------------------------------------------------------
`include "rms_onset_detector_assert.svh"

module rod_back #(
    parameter  int MAX_WINDOW = rod_pkg::MAX_WINDOW_DEF,
    parameter  int INDEX_BITS = rod_pkg::INDEX_BITS_DEF,
    localparam int QDATA_W    = INDEX_BITS + 1 + $bits(rod_pkg::item_t)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rod_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  logic [QDATA_W-1:0]  q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output rod_pkg::result_t    result
);
    import rod_pkg::*;

    localparam int ITEM_W    = $bits(item_t);
    localparam int PTR_W     = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W     = $clog2(MAX_WINDOW) + SQ_W;
    localparam int W_CLAMP   = (MAX_WINDOW > (2 ** WLEN_W) - 1) ? (2 ** WLEN_W) - 1 : MAX_WINDOW;
    localparam int CMP_W     = ((INDEX_BITS > SEARCH_W) ? INDEX_BITS : SEARCH_W) + 1;
    localparam int IW1       = INDEX_BITS + 1;
    localparam int LW        = ((PTR_W > WLEN_W) ? PTR_W : WLEN_W) + 2;

    back_state_t            state_reg, state_next;

    // Item under work
    logic [INDEX_BITS-1:0]  idx_reg, idx_next;
    logic                   store_reg, store_next;
    logic [SAMPLE_W-1:0]    sample_reg, sample_next;
    logic                   last_reg, last_next;

    // Stream state
    logic [PTR_W-1:0]       pos_reg, pos_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [WLEN_W-1:0]      w_used_reg, w_used_next;
    logic [INDEX_BITS-1:0]  start_reg, start_next;
    logic [ROOT_W-1:0]      prev_reg, prev_next;
    logic [RISE_W-1:0]      best_reg, best_next;
    logic [INDEX_BITS-1:0]  best_start_reg, best_start_next;
    logic [WLEN_W-1:0]      rc_left_reg, rc_left_next;
    logic [PTR_W-1:0]       rc_ptr_reg, rc_ptr_next;

    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;

    logic [SQ_W-1:0]        sq_reg;
    logic [SAMPLE_W-1:0]    sq_src;

    // Ring memory
    logic [SAMPLE_W-1:0]    ring_mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0]    ring_rdata_reg;
    logic                   ring_we, ring_re;
    logic [PTR_W-1:0]       ring_raddr;

    // Root unit
    logic                   root_start;
    root_stat_t             root_stat;
    logic [ROOT_W-1:0]      rms;

    logic [WLEN_W-1:0]      w_eff;
    logic [STEP_W-1:0]      st_eff;
    logic [PTR_W-1:0]       pos_inc;
    logic [LW-1:0]          leave_raw;
    logic [PTR_W-1:0]       leave_addr;
    logic [CMP_W-1:0]       idx1, win_end;
    logic [IW1-1:0]         adv;
    logic [RISE_W-1:0]      cand_rise;
    logic                   emit;

    // Clamp the configured lengths.
    always_comb
    begin
        w_eff = cfg.window_len;
        if (w_eff == '0)
        begin
            w_eff = WLEN_W'(1);
        end
        else if (w_eff > WLEN_W'(W_CLAMP))
        begin
            w_eff = WLEN_W'(W_CLAMP);
        end
        st_eff = (cfg.step_len == '0) ? STEP_W'(1) : cfg.step_len;
    end

    assign pos_inc    = (pos_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : pos_reg + 1'b1;
    assign leave_raw  = LW'(pos_reg) + LW'(MAX_WINDOW) - LW'(w_eff);
    assign leave_addr = (leave_raw >= LW'(MAX_WINDOW)) ? PTR_W'(leave_raw - LW'(MAX_WINDOW))
                                                       : PTR_W'(leave_raw);
    assign idx1       = CMP_W'(idx_reg) + CMP_W'(1);
    assign win_end    = CMP_W'(start_reg) + CMP_W'(w_eff);
    assign adv        = IW1'(start_reg) + IW1'(st_eff);
    assign cand_rise  = rms - prev_reg;

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        store_next      = store_reg;
        sample_next     = sample_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        w_used_next     = w_used_reg;
        start_next      = start_reg;
        prev_next       = prev_reg;
        best_next       = best_reg;
        best_start_next = best_start_reg;
        rc_left_next    = rc_left_reg;
        rc_ptr_next     = rc_ptr_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        q_pop           = 1'b0;
        ring_we         = 1'b0;
        ring_re         = 1'b0;
        ring_raddr      = leave_addr;
        sq_src          = sample_reg;
        root_start      = 1'b0;
        emit            = 1'b0;

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    idx_next    = q_data[ITEM_W+1 +: INDEX_BITS];
                    store_next  = q_data[ITEM_W];
                    sample_next = q_data[ITEM_W-1 -: SAMPLE_W];
                    last_next   = q_data[0];
                    state_next  = B_CLASS;
                end
            end
            B_CLASS:
            begin
                if (!store_reg)
                begin
                    state_next = B_FINISH;
                end
                else
                begin
                    ring_we  = 1'b1;
                    pos_next = pos_inc;
                    if (w_eff != w_used_reg)
                    begin
                        // Window length changed: rebuild the sum from the ring.
                        sum_next     = '0;
                        w_used_next  = w_eff;
                        rc_ptr_next  = pos_reg;
                        rc_left_next = (idx1 < CMP_W'(w_eff)) ? idx1[WLEN_W-1:0] : w_eff;
                        state_next   = B_RC_READ;
                    end
                    else
                    begin
                        // Fetch the sample that slides out before it is overwritten.
                        ring_re    = 1'b1;
                        state_next = B_ADD;
                    end
                end
            end
            B_ADD:
            begin
                sum_next = sum_reg + SUM_W'(sq_reg);
                sq_src   = ring_rdata_reg;
                if (idx_reg >= INDEX_BITS'(w_used_reg))
                begin
                    state_next = B_SUB;
                end
                else
                begin
                    state_next = B_CHECK;
                end
            end
            B_SUB:
            begin
                sum_next   = sum_reg - SUM_W'(sq_reg);
                state_next = B_CHECK;
            end
            B_RC_READ:
            begin
                ring_re      = 1'b1;
                ring_raddr   = rc_ptr_reg;
                rc_ptr_next  = (rc_ptr_reg == '0) ? PTR_W'(MAX_WINDOW - 1) : rc_ptr_reg - 1'b1;
                rc_left_next = rc_left_reg - 1'b1;
                state_next   = B_RC_SQ;
            end
            B_RC_SQ:
            begin
                sq_src     = ring_rdata_reg;
                state_next = B_RC_ACC;
            end
            B_RC_ACC:
            begin
                sum_next   = sum_reg + SUM_W'(sq_reg);
                state_next = (rc_left_reg == '0) ? B_CHECK : B_RC_READ;
            end
            B_CHECK:
            begin
                if (idx1 >= win_end)
                begin
                    if (win_end < CMP_W'(cfg.search_end))
                    begin
                        root_start = 1'b1;
                        state_next = B_ROOT;
                    end
                    else
                    begin
                        state_next = B_ADVANCE;
                    end
                end
                else
                begin
                    state_next = B_FINISH;
                end
            end
            B_ROOT:
            begin
                if (root_stat.done)
                begin
                    state_next = B_UPDATE;
                end
            end
            B_UPDATE:
            begin
                if ((rms > prev_reg) && (cand_rise > best_reg))
                begin
                    best_next       = cand_rise;
                    best_start_next = start_reg;
                end
                prev_next  = rms;
                state_next = B_ADVANCE;
            end
            B_ADVANCE:
            begin
                start_next = adv[INDEX_BITS] ? {INDEX_BITS{1'b1}} : adv[INDEX_BITS-1:0];
                state_next = B_FINISH;
            end
            B_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (!res_valid_reg)
                begin
                    // Post the result and clear the sum, positions and onset tracking.
                    emit                 = 1'b1;
                    res_valid_next       = 1'b1;
                    res_next.onset_index = ONSET_W'(best_start_reg);
                    res_next.rise        = best_reg;
                    res_next.found       = (best_reg != '0);
                    sum_next             = '0;
                    start_next           = '0;
                    prev_next            = '0;
                    best_next            = '0;
                    best_start_next      = '0;
                    pos_next             = '0;
                    state_next           = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pos_reg        <= '0;
            sum_reg        <= '0;
            w_used_reg     <= '0;
            start_reg      <= '0;
            prev_reg       <= '0;
            best_reg       <= '0;
            best_start_reg <= '0;
            rc_left_reg    <= '0;
            rc_ptr_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            w_used_reg     <= w_used_next;
            start_reg      <= start_next;
            prev_reg       <= prev_next;
            best_reg       <= best_next;
            best_start_reg <= best_start_next;
            rc_left_reg    <= rc_left_next;
            rc_ptr_reg     <= rc_ptr_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        store_reg  <= store_next;
        sample_reg <= sample_next;
        last_reg   <= last_next;
        res_reg    <= res_next;
        sq_reg     <= square(sq_src);
    end

    // Read before write at the same address returns the old sample.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        if (ring_re)
        begin
            ring_rdata_reg <= ring_mem[ring_raddr];
        end
    end

    rod_root #(
        .SUM_W    (SUM_W)
    ) u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (sum_reg),
        .divisor  (w_eff),
        .stat     (root_stat),
        .root     (rms)
    );

    `ROD_ASSERT_IMP(a_root_idle_on_start, clk, rst_n, root_start, !root_stat.busy, "root unit started while busy")
    `ROD_ASSERT_NXT(a_done_to_update, clk, rst_n, root_stat.done, state_reg == B_UPDATE, "root result not taken")
    `ROD_ASSERT_NXT(a_emit_clears, clk, rst_n, emit, res_valid_reg && (best_reg == '0) && (start_reg == '0) && (pos_reg == '0), "stream state not cleared after result")

endmodule

### hw/rtl/rms_onset_detector.sv
// ----------------------------------------------------------------------------
// rms_onset_detector
// Short-time RMS energy onset detector: finds the window start with the
// largest rise in integer RMS over a stream of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter through a queue-style port: a beat moves when push is high
//   and full is low. Set last on the final sample of a stream; that beat
//   yields one result (onset_index, rise, found), and the block then starts
//   a fresh stream. Results leave through empty/pop: the oldest result sits
//   on the result port while empty is low and moves when pop is high.
//   The user writes registers (window_len 0x0, step_len 0x4, search_end 0x8)
//   over the APB port only while the block is idle; this is not enforced.
// Processing:
//   A sample that closes no window passes the class, add/subtract and check
//   states from the queue head. A counted window close adds the divider (one
//   bit per cycle over the window sum) and then the square root.
//   The first sample after a change of window_len rebuilds the sum from the
//   ring, reading, squaring and adding each stored sample in the window.
// Reset and stalls:
//   Reset clears all stream state and loads the register defaults; the ring
//   memory is not cleared. A held result blocks only the next last beat;
//   the two-entry queue keeps taking samples until it fills.
// ----------------------------------------------------------------------------
module rms_onset_detector #(
    parameter int MAX_WINDOW = rod_pkg::MAX_WINDOW_DEF,
    parameter int INDEX_BITS = rod_pkg::INDEX_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rod_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rod_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rod_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // Sample channel
    input  logic                           push,
    output logic                           full,
    input  rod_pkg::item_t                 item,
    // Result channel
    output logic                           empty,
    input  logic                           pop,
    output rod_pkg::result_t               result
);
    import rod_pkg::*;

    localparam int QDATA_W = INDEX_BITS + 1 + $bits(item_t);

    cfg_t                cfg_reg, cfg_next;
    logic                cfg_wr;
    logic [1:0]          reg_sel;

    logic                q_full, q_empty, q_push, q_pop;
    logic [QDATA_W-1:0]  q_wdata, q_rdata;

    // Register access: byte address 4*i, word-aligned decode.
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_WINDOW_LEN: cfg_next.window_len = pwdata[WLEN_W-1:0];
                REG_STEP_LEN:   cfg_next.step_len   = pwdata[STEP_W-1:0];
                REG_SEARCH_END: cfg_next.search_end = pwdata[SEARCH_W-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WINDOW_LEN: prdata = APB_DATA_W'(cfg_reg.window_len);
            REG_STEP_LEN:   prdata = APB_DATA_W'(cfg_reg.step_len);
            REG_SEARCH_END: prdata = APB_DATA_W'(cfg_reg.search_end);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_len <= WINDOW_LEN_RST;
            cfg_reg.step_len   <= STEP_LEN_RST;
            cfg_reg.search_end <= SEARCH_END_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: number samples and flag the saturated index.
    rod_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // Hold classified beats while the back end grinds through a window.
    rod_queue #(
        .DATA_W  (QDATA_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: ring, sums, window close, onset tracking and result register.
    rod_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule
